// File: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check of a property, sampled on the rising clock edge.
`define ASSERT_CLK(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Expression must never be true while out of reset.
`define ASSERT_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

// File: hdl/rtvs_pkg.sv
// ----------------------------------------------------------------------------
// rtvs_pkg
// Shared types and constants of the region tetrahedron volume sum unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rtvs_pkg;

   localparam int REGIONS_DEF    = 64;
   localparam int COORD_BITS_DEF = 16;

   localparam int LANE_BITS   = 16;
   localparam int POINT_BITS  = 3 * LANE_BITS;
   localparam int REGION_BITS = 6;
   localparam int SUM_BITS    = 64;
   localparam int VOL_BITS    = 62;

   // saturated accumulator divided by six
   localparam logic [VOL_BITS-1:0] VOL_MAX = 62'd3074457345618258602;

   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_READ = 1'b1
   } op_type;

endpackage

`default_nettype wire

// File: hdl/rtvs_ram.sv
// ----------------------------------------------------------------------------
// rtvs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rtvs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/region_tetrahedron_volume_sum_unit.sv
// ----------------------------------------------------------------------------
// region_tetrahedron_volume_sum_unit
// Per-region sum of tetrahedron volumes from the scalar triple product.
// ----------------------------------------------------------------------------
// An add beat (req_operation = 0) takes four vertices and a region; the block
// stays busy for nine passes through one shared signed multiplier
// (COORD_BITS+1 by 2*COORD_BITS+3 bits), a drain step for its output
// register, and one read-modify-write of the 64-bit region accumulator RAM,
// so a new add is taken only once it is idle again. An add whose region
// is at or above REGIONS is dropped without going busy. A readout beat
// (req_operation = 1) walks the regions in ascending order: a scan step per
// absent region and, per present region, a scan step, a RAM fetch and sixteen
// 4-bit steps of the divide-by-six; each region is cleared as it is read.
// Each result is shown for exactly one cycle on rsp_valid and cannot be held
// off; rsp_last marks the final one. An empty readout gives no result and
// returns idle from its scan state. No clearing pass is needed after reset.
`default_nettype none

module region_tetrahedron_volume_sum_unit #(
   parameter int REGIONS    = rtvs_pkg::REGIONS_DEF,
   parameter int COORD_BITS = rtvs_pkg::COORD_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_operation,
   input  logic [rtvs_pkg::REGION_BITS-1:0] req_region,
   input  logic [rtvs_pkg::POINT_BITS-1:0]  req_point_a,
   input  logic [rtvs_pkg::POINT_BITS-1:0]  req_point_b,
   input  logic [rtvs_pkg::POINT_BITS-1:0]  req_point_c,
   input  logic [rtvs_pkg::POINT_BITS-1:0]  req_point_d,
   output logic                             rsp_valid,
   output logic [rtvs_pkg::REGION_BITS-1:0] rsp_region_out,
   output logic [rtvs_pkg::VOL_BITS-1:0]    rsp_volume,
   output logic                             rsp_last
);

   import rtvs_pkg::*;

   localparam int AW  = (REGIONS > 1) ? $clog2(REGIONS) : 1;
   localparam int CW  = $clog2(REGIONS + 1);
   localparam int EW  = COORD_BITS + 1;         // edge component
   localparam int CRW = 2 * COORD_BITS + 3;     // cross product component
   localparam int PW  = EW + CRW;               // multiplier output
   localparam int DW  = 3 * COORD_BITS + 6;     // triple product

   localparam logic [3:0] LAST_MUL_STEP = 4'd8;
   localparam logic [3:0] DRAIN_STEP    = 4'd9;
   localparam logic [3:0] FIRST_DOT     = 4'd6;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_WRITE,
      S_SCAN,
      S_FETCH,
      S_DIV
   } state_type;

   // {quotient digit, remainder} of a 7-bit value (below 96) divided by six
   function automatic logic [6:0] div6_step(input logic [6:0] val);
      logic [3:0] q;
      logic [6:0] six_q;
      logic [6:0] r;
      q = '0;
      for (int k = 1; k < 16; k++) begin
         if (val >= 7'(6 * k)) begin
            q = 4'(k);
         end
      end
      six_q = ({3'b000, q} << 2) + ({3'b000, q} << 1);
      r     = val - six_q;
      return {q, r[2:0]};
   endfunction

   // ---------------------------------------------------------------- registers
   state_type               state_ff, state_in;
   logic [3:0]              step_ff, step_in;
   logic [AW-1:0]           region_ff, region_in;
   logic signed [EW-1:0]    e1_ff [3], e1_in [3];
   logic signed [EW-1:0]    e2_ff [3], e2_in [3];
   logic signed [EW-1:0]    e3_ff [3], e3_in [3];
   logic signed [PW-1:0]    prod_ff, prod_in;
   logic                    prod_vld_ff, prod_vld_in;
   logic [3:0]              prod_step_ff, prod_step_in;
   logic signed [CRW-1:0]   cr_ff [3], cr_in [3];
   logic signed [DW-1:0]    dot_ff, dot_in;
   logic [REGIONS-1:0]      present_ff, present_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [AW-1:0]           idx_ff, idx_in;
   logic [SUM_BITS-1:0]     div_ff, div_in;
   logic [2:0]              rem_ff, rem_in;
   logic [3:0]              nib_ff, nib_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [REGION_BITS-1:0]  rsp_region_ff, rsp_region_in;
   logic [VOL_BITS-1:0]     rsp_volume_ff, rsp_volume_in;
   logic                    rsp_last_ff, rsp_last_in;

   // ------------------------------------------------------------ combinational
   logic                    accept;
   logic                    region_ok;
   logic signed [EW-1:0]    mul_a;
   logic signed [CRW-1:0]   mul_b;
   logic [1:0]              cr_idx;
   logic signed [DW-1:0]    prod_ext;
   logic [DW-1:0]           dot_abs;
   logic [SUM_BITS-1:0]     old_sum;
   logic [SUM_BITS:0]       sum_wide;
   logic [SUM_BITS-1:0]     sum_sat;
   logic [6:0]              digit;
   logic [SUM_BITS-1:0]     div_next;
   logic                    ram_wr_en;
   logic [AW-1:0]           ram_rd_addr;
   logic [SUM_BITS-1:0]     ram_rd_data;

   assign accept    = start && (state_ff == S_IDLE);
   assign region_ok = ({1'b0, req_region} < (REGION_BITS + 1)'(REGIONS));

   // shared multiplier operand select
   always_comb begin
      case (step_ff)
         4'd0: begin mul_a = e2_ff[1]; mul_b = CRW'(e3_ff[2]); end
         4'd1: begin mul_a = e2_ff[2]; mul_b = CRW'(e3_ff[1]); end
         4'd2: begin mul_a = e2_ff[2]; mul_b = CRW'(e3_ff[0]); end
         4'd3: begin mul_a = e2_ff[0]; mul_b = CRW'(e3_ff[2]); end
         4'd4: begin mul_a = e2_ff[0]; mul_b = CRW'(e3_ff[1]); end
         4'd5: begin mul_a = e2_ff[1]; mul_b = CRW'(e3_ff[0]); end
         4'd6: begin mul_a = e1_ff[0]; mul_b = cr_ff[0]; end
         4'd7: begin mul_a = e1_ff[1]; mul_b = cr_ff[1]; end
         default: begin mul_a = e1_ff[2]; mul_b = cr_ff[2]; end
      endcase
   end

   assign cr_idx   = prod_step_ff[2:1];
   assign prod_ext = DW'(prod_ff);

   assign dot_abs  = dot_ff[DW-1] ? DW'(-dot_ff) : DW'(dot_ff);
   assign old_sum  = present_ff[region_ff] ? ram_rd_data : '0;
   assign sum_wide = {1'b0, old_sum} + {1'b0, SUM_BITS'(dot_abs)};
   assign sum_sat  = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];

   assign digit    = div6_step({rem_ff, div_ff[SUM_BITS-1 -: 4]});
   assign div_next = {div_ff[SUM_BITS-5:0], digit[6:3]};

   assign ram_wr_en   = (state_ff == S_WRITE);
   assign ram_rd_addr = (state_ff == S_SCAN) ? idx_ff : region_ff;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      region_in     = region_ff;
      e1_in         = e1_ff;
      e2_in         = e2_ff;
      e3_in         = e3_ff;
      prod_in       = PW'(mul_a) * PW'(mul_b);
      prod_vld_in   = (state_ff == S_MUL) && (step_ff <= LAST_MUL_STEP);
      prod_step_in  = step_ff;
      cr_in         = cr_ff;
      dot_in        = dot_ff;
      present_in    = present_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      nib_in        = nib_ff;
      rsp_valid_in  = 1'b0;
      rsp_region_in = rsp_region_ff;
      rsp_volume_in = rsp_volume_ff;
      rsp_last_in   = rsp_last_ff;

      // accumulate the product registered last cycle
      if (prod_vld_ff) begin
         if (prod_step_ff < FIRST_DOT) begin
            if (!prod_step_ff[0]) begin
               cr_in[cr_idx] = prod_ff[CRW-1:0];
            end else begin
               cr_in[cr_idx] = cr_ff[cr_idx] - prod_ff[CRW-1:0];
            end
         end else if (prod_step_ff == FIRST_DOT) begin
            dot_in = prod_ext;
         end else begin
            dot_in = dot_ff + prod_ext;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_operation == OP_READ) begin
                  idx_in   = '0;
                  state_in = S_SCAN;
               end else if (region_ok) begin
                  region_in = req_region[AW-1:0];
                  step_in   = '0;
                  for (int i = 0; i < 3; i++) begin
                     e1_in[i] = EW'($signed(req_point_a[i*LANE_BITS +: COORD_BITS]))
                              - EW'($signed(req_point_d[i*LANE_BITS +: COORD_BITS]));
                     e2_in[i] = EW'($signed(req_point_b[i*LANE_BITS +: COORD_BITS]))
                              - EW'($signed(req_point_d[i*LANE_BITS +: COORD_BITS]));
                     e3_in[i] = EW'($signed(req_point_c[i*LANE_BITS +: COORD_BITS]))
                              - EW'($signed(req_point_d[i*LANE_BITS +: COORD_BITS]));
                  end
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            step_in = step_ff + 4'd1;
            if (step_ff == DRAIN_STEP) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            present_in[region_ff] = 1'b1;
            if (!present_ff[region_ff]) begin
               count_in = count_ff + CW'(1);
            end
            state_in = S_IDLE;
         end
         S_SCAN: begin
            if (count_ff == '0) begin
               state_in = S_IDLE;
            end else if (present_ff[idx_ff]) begin
               state_in = S_FETCH;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         S_FETCH: begin
            div_in   = ram_rd_data;
            rem_in   = '0;
            nib_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            div_in = div_next;
            rem_in = digit[2:0];
            nib_in = nib_ff + 4'd1;
            if (&nib_ff) begin
               rsp_valid_in       = 1'b1;
               rsp_region_in      = REGION_BITS'(idx_ff);
               rsp_volume_in      = div_next[VOL_BITS-1:0];
               rsp_last_in        = (count_ff == CW'(1));
               present_in[idx_ff] = 1'b0;
               count_in           = count_ff - CW'(1);
               idx_in             = idx_ff + AW'(1);
               state_in           = (count_ff == CW'(1)) ? S_IDLE : S_SCAN;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prod_vld_ff  <= 1'b0;
         present_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prod_vld_ff  <= prod_vld_in;
         present_ff   <= present_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff       <= step_in;
      region_ff     <= region_in;
      e1_ff         <= e1_in;
      e2_ff         <= e2_in;
      e3_ff         <= e3_in;
      prod_ff       <= prod_in;
      prod_step_ff  <= prod_step_in;
      cr_ff         <= cr_in;
      dot_ff        <= dot_in;
      idx_ff        <= idx_in;
      div_ff        <= div_in;
      rem_ff        <= rem_in;
      nib_ff        <= nib_in;
      rsp_region_ff <= rsp_region_in;
      rsp_volume_ff <= rsp_volume_in;
      rsp_last_ff   <= rsp_last_in;
   end

   rtvs_ram #(
      .WIDTH (SUM_BITS),
      .DEPTH (REGIONS),
      .AW    (AW)
   ) u_sums (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (region_ff),
      .wr_data (sum_sat),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_region_out = rsp_region_ff;
   assign rsp_volume     = rsp_volume_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

// File: hdl/rtvs_chk.sv
// ----------------------------------------------------------------------------
// rtvs_chk
// Port-level checks of the region tetrahedron volume sum unit, bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rtvs_chk (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic                          req_operation,
   input wire logic                          rsp_valid,
   input wire logic [rtvs_pkg::VOL_BITS-1:0] rsp_volume,
   input wire logic                          rsp_last
);

   import rtvs_pkg::*;

   // an add beat never produces a result
   `ASSERT_CLK(a_add_no_rsp, clock, reset, (start && !busy && req_operation == OP_ADD) |=> !rsp_valid)

   // results never come back to back; they are spaced by the divide steps
   `ASSERT_CLK(a_rsp_spaced, clock, reset, rsp_valid |=> !rsp_valid)

   // the last beat of a readout leaves the block free
   `ASSERT_CLK(a_last_frees, clock, reset, (rsp_valid && rsp_last) |-> !busy)

   // a saturated accumulator is the largest reportable volume
   `ASSERT_NEVER(a_vol_range, clock, reset, rsp_valid && (rsp_volume > VOL_MAX))

endmodule

bind region_tetrahedron_volume_sum_unit rtvs_chk u_chk (.*);

`default_nettype wire
